FILE: src/cdq_pkg.sv
// Package for the circular deque unit: request and status codes, cell
// commands, sequencer states and the control struct of the cell row.
// No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

  // Default number of cells in the row
  localparam int unsigned DEPTH_DEF = 8;

  // Word and field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned STAT_W = 3;

  typedef logic signed [WORD_W-1:0] word_t;

  // Restriction mode register values
  localparam logic MODE_IN_RESTR  = 1'b0;  // no front insert
  localparam logic MODE_OUT_RESTR = 1'b1;  // no rear delete

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_REAR  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_LIST       = 3'd4
  } req_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_OVER    = 3'd1,
    STAT_UNDER   = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_REFUSED = 3'd4
  } stat_e;

  // Command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_REAR,
    CELL_POP_FRONT,
    CELL_ROTATE
  } cell_cmd_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

  // Control group from the sequencer to the cell row
  typedef struct packed {
    cell_cmd_e cmd;
    word_t     item;
  } cell_ctrl_t;

endpackage

FILE: src/cdq_cell.sv
// One cell of the deque row: holds one word and takes its next value from
// its left or right neighbour, the front cell or the new item.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_cell (
  input  logic               clk_i,
  input  cdq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,       // this cell holds a queued word
  input  logic               occ_prev_i,  // left neighbour occupied (or row start)
  input  logic               occ_next_i,  // right neighbour occupied
  input  cdq_pkg::word_t     left_i,
  input  cdq_pkg::word_t     right_i,
  input  cdq_pkg::word_t     wrap_i,      // word of the front cell
  output cdq_pkg::word_t     data_o,
  output cdq_pkg::word_t     tail_o       // own word if this is the rear cell, else zero
);

  cdq_pkg::word_t data_q;
  cdq_pkg::word_t data_d;

  // Pick the next word for this cell
  always_comb begin
    data_d = data_q;
    case (ctrl_i.cmd)
      cdq_pkg::CELL_PUSH_FRONT: data_d = left_i;
      cdq_pkg::CELL_PUSH_REAR: begin
        if (!occ_i && occ_prev_i) begin
          data_d = ctrl_i.item;
        end
      end
      cdq_pkg::CELL_POP_FRONT: data_d = right_i;
      cdq_pkg::CELL_ROTATE:    data_d = occ_next_i ? right_i : wrap_i;
      default:                 data_d = data_q;
    endcase
  end

  // Hold the word
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tail_o = (occ_i && !occ_next_i) ? data_q : '0;

endmodule

FILE: src/circular_deque_unit.sv
// Double-ended queue built from a row of word cells with the front in cell 0.
// An accepted request's first result is loaded into the output register in the next cycle.
// Inserts, deletes and refused or failed requests give one result each, and a new request
// is taken when the output register is free; a listing gives one stored word per cycle by
// rotating the cell row while the result stream does not stall (one result when empty).
// Reset clears fill count, sequencer, output valid flag and mode; cell words and payload stay.
`timescale 1ns / 1ps

module circular_deque_unit #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Mode register write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_data_i,     // [0] restrict_mode
  // Request stream
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [cdq_pkg::WORD_W-1:0] s_axis_tdata_i, // [31:0] item_value
  input  logic [cdq_pkg::REQ_W-1:0]  s_axis_tuser_i, // [2:0] req_type
  // Result stream
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [cdq_pkg::WORD_W-1:0] m_axis_tdata_o, // [31:0] data_out
  output logic [cdq_pkg::STAT_W-1:0] m_axis_tuser_o, // [2:0] status
  output logic                       m_axis_tlast_o  // last_flag
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Mode register
  logic mode_q;

  // Fill count and listing countdown
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;

  cdq_pkg::state_e state_q, state_d;

  // Output register
  logic                  out_valid_q;
  cdq_pkg::stat_e        out_stat_q, out_stat_d;
  cdq_pkg::word_t        out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;
  logic                  load_out;

  // Cell row
  cdq_pkg::cell_ctrl_t   ctrl;
  cdq_pkg::word_t        cell_data [DEPTH];
  cdq_pkg::word_t        cell_tail [DEPTH];
  logic [DEPTH-1:0]      occ;
  cdq_pkg::word_t        tail_word;

  logic           in_acc;
  logic           out_free;
  cdq_pkg::req_e  req;
  logic           full;
  logic           empty;

  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == cdq_pkg::ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign req             = cdq_pkg::req_e'(s_axis_tuser_i);
  assign full            = (count_q == CntW'(DEPTH));
  assign empty           = (count_q == '0);

  // Occupancy of each cell from the fill count
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (count_q > CntW'(i));
    end
  end

  // Build the row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cdq_pkg::word_t left_w;
    cdq_pkg::word_t right_w;
    logic           prev_w;
    logic           next_w;

    if (g == 0) begin : g_first
      assign left_w = ctrl.item;
      assign prev_w = 1'b1;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
      assign prev_w = occ[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
      assign next_w  = 1'b0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
      assign next_w  = occ[g+1];
    end

    cdq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ[g]),
      .occ_prev_i (prev_w),
      .occ_next_i (next_w),
      .left_i     (left_w),
      .right_i    (right_w),
      .wrap_i     (cell_data[0]),
      .data_o     (cell_data[g]),
      .tail_o     (cell_tail[g])
    );
  end

  // Gather the rear word: only the rear cell drives a nonzero value
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_word = tail_word | cell_tail[i];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cdq_pkg::ST_IDLE: begin
        if (in_acc && req == cdq_pkg::REQ_LIST && count_q > CntW'(1)) begin
          state_d = cdq_pkg::ST_LIST;
        end
      end
      cdq_pkg::ST_LIST: begin
        if (out_free && rem_q == CntW'(1)) begin
          state_d = cdq_pkg::ST_IDLE;
        end
      end
      default: state_d = cdq_pkg::ST_IDLE;
    endcase
  end

  // Decode requests, drive the row and form results
  always_comb begin
    ctrl.cmd   = cdq_pkg::CELL_HOLD;
    ctrl.item  = cdq_pkg::word_t'(s_axis_tdata_i);
    load_out   = 1'b0;
    out_stat_d = cdq_pkg::STAT_OK;
    out_data_d = '0;
    out_last_d = 1'b1;
    count_d    = count_q;
    rem_d      = rem_q;
    case (state_q)
      cdq_pkg::ST_IDLE: begin
        if (in_acc) begin
          load_out = 1'b1;
          case (req)
            cdq_pkg::REQ_PUSH_REAR, cdq_pkg::REQ_PUSH_FRONT: begin
              if (req == cdq_pkg::REQ_PUSH_FRONT && mode_q == cdq_pkg::MODE_IN_RESTR) begin
                out_stat_d = cdq_pkg::STAT_REFUSED;
              end else if (full) begin
                out_stat_d = cdq_pkg::STAT_OVER;
              end else begin
                ctrl.cmd = (req == cdq_pkg::REQ_PUSH_FRONT) ? cdq_pkg::CELL_PUSH_FRONT
                                                            : cdq_pkg::CELL_PUSH_REAR;
                count_d  = count_q + CntW'(1);
              end
            end
            cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
              if (req == cdq_pkg::REQ_POP_REAR && mode_q == cdq_pkg::MODE_OUT_RESTR) begin
                out_stat_d = cdq_pkg::STAT_REFUSED;
              end else if (empty) begin
                out_stat_d = cdq_pkg::STAT_UNDER;
              end else begin
                if (req == cdq_pkg::REQ_POP_FRONT) begin
                  ctrl.cmd   = cdq_pkg::CELL_POP_FRONT;
                  out_data_d = cell_data[0];
                end else begin
                  out_data_d = tail_word;
                end
                count_d = count_q - CntW'(1);
              end
            end
            cdq_pkg::REQ_LIST: begin
              if (empty) begin
                out_stat_d = cdq_pkg::STAT_EMPTY;
              end else begin
                ctrl.cmd   = cdq_pkg::CELL_ROTATE;
                out_data_d = cell_data[0];
                out_last_d = (count_q == CntW'(1));
                rem_d      = count_q - CntW'(1);
              end
            end
            default: out_stat_d = cdq_pkg::STAT_REFUSED;
          endcase
        end
      end
      cdq_pkg::ST_LIST: begin
        if (out_free) begin
          load_out   = 1'b1;
          ctrl.cmd   = cdq_pkg::CELL_ROTATE;
          out_data_d = cell_data[0];
          out_last_d = (rem_q == CntW'(1));
          rem_d      = rem_q - CntW'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdq_pkg::ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      mode_q      <= cdq_pkg::MODE_IN_RESTR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_stat_q <= out_stat_d;
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tlast_o  = out_last_q;

  // Fill count stays within the row
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count beyond depth");

  // No request taken while a listing runs
  a_list_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cdq_pkg::ST_LIST |-> !s_axis_tready_o)
    else $error("request accepted during listing");

  // Fill count moves only on an accepted item
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(count_q))
    else $error("fill count changed without a request");

  // A pending result outside a listing is always the final one of its request
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && state_q == cdq_pkg::ST_IDLE |-> out_last_q)
    else $error("unfinished request left in idle");

endmodule
